### rtl/core/bpfa_pkg.sv
package bpfa_pkg;

	localparam int FRAME_COUNT_DEF = 64;
	localparam int MAX_JOBS_DEF    = 16;
	localparam int PAGES_PER_JOB   = 64;
	localparam int PAGE_W          = 6;
	localparam int FRAME_W         = 6;
	localparam int COUNT_W         = 7;
	localparam int ID_W            = 16;
	localparam logic [63:0] PRESET_MAP = 64'h0000_0000_8100_2A73;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_LOOKUP  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_NOFRAMES  = 3'd1,
		STATUS_FULL      = 3'd2,
		STATUS_NOJOB     = 3'd3,
		STATUS_BADREQ    = 3'd4,
		STATUS_RANGE     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_DECIDE,
		ST_ALLOC,
		ST_REL,
		ST_LOOK,
		ST_REPLY
	} state_t;

	typedef struct packed {
		mode_t               mode;
		logic [ID_W-1:0]     job_id;
		logic [COUNT_W-1:0]  page_count;
		logic [PAGE_W-1:0]   page_index;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [FRAME_W-1:0]  frame;
		logic [PAGE_W-1:0]   page_number;
		logic [COUNT_W-1:0]  frames_used;
		logic                last;
	} out_item_t;

	function automatic int popcount64(input logic [63:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 64; i++) begin
			n = n + int'(v[i]);
		end
		return n;
	endfunction

endpackage

### rtl/core/bitmap_page_frame_allocator_core.sv
// Bitmap page frame allocator. Each transaction on the input channel is an
// allocate, release or lookup request for one job; the block answers with one
// result transaction, except a successful allocate, which yields one result per
// page in ascending frame order with last set on the final one. The block works
// on one request at a time and drops in_ready until its last result has been
// loaded into the output register. Every request first walks the job table one
// slot per cycle with a single shared name comparator. An allocate then scans
// the frame bitmap one frame per cycle from frame zero while the output
// register is free, and waits while the output is stalled. A release reads the
// page table one page per cycle through the memory read port and clears those
// frames. A lookup reads its entry through the registered memory read port.
// After reset the bitmap holds the ten preset busy frames and no job is active;
// no clearing pass is needed.
module bitmap_page_frame_allocator_core #(
	parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF,
	parameter int MAX_JOBS    = bpfa_pkg::MAX_JOBS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpfa_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bpfa_pkg::out_item_t out_item
);

	localparam int FIDX_W = $clog2(FRAME_COUNT);
	localparam int SLOT_W = $clog2(MAX_JOBS);
	localparam int ADDR_W = SLOT_W + bpfa_pkg::PAGE_W;
	localparam logic [FRAME_COUNT-1:0] PRESET = bpfa_pkg::PRESET_MAP[FRAME_COUNT-1:0];
	localparam int PRESET_USED = bpfa_pkg::popcount64(64'(PRESET));

	// Sequencer state and the latched request.
	bpfa_pkg::state_t   state_q, state_d;
	bpfa_pkg::in_item_t cmd_q;

	// Job table.
	logic [MAX_JOBS-1:0]           job_valid_q;
	logic [bpfa_pkg::ID_W-1:0]     job_name_q  [MAX_JOBS];
	logic [bpfa_pkg::COUNT_W-1:0]  job_pages_q [MAX_JOBS];

	// Search results.
	logic [SLOT_W-1:0]            slot_q;
	logic                         hit_q, free_q;
	logic [SLOT_W-1:0]            hit_slot_q, free_slot_q;
	logic [bpfa_pkg::COUNT_W-1:0] pages_q;

	// Frame bitmap and its population count.
	logic [FRAME_COUNT-1:0]       frame_map_q;
	logic [bpfa_pkg::COUNT_W-1:0] used_q;
	logic [FIDX_W-1:0]            frame_cnt_q;
	logic [bpfa_pkg::COUNT_W-1:0] page_cnt_q;
	logic [bpfa_pkg::COUNT_W-1:0] alloc_total_q;
	logic                         rel_v_s1;

	// Single-result reply fields.
	bpfa_pkg::status_t            reply_status_q;
	logic [bpfa_pkg::FRAME_W-1:0] reply_frame_q;
	logic [bpfa_pkg::PAGE_W-1:0]  reply_page_q;

	// Output register.
	logic                out_valid_q;
	bpfa_pkg::out_item_t out_q;

	// Page table memory.
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
	logic [bpfa_pkg::FRAME_W-1:0] ram_wdata, ram_rdata;

	// Combinational control.
	logic                         out_free;
	logic                         slot_match;
	logic                         slot_last;
	logic [bpfa_pkg::COUNT_W-1:0] free_frames;
	bpfa_pkg::state_t             dec_state;
	bpfa_pkg::status_t            dec_status;
	logic                         alloc_take, alloc_last, alloc_step;
	logic                         rel_issue, rel_done;
	logic [FIDX_W-1:0]            rel_frame;
	logic                         out_load;
	bpfa_pkg::out_item_t          out_next;

	assign out_free    = !out_valid_q || out_ready;
	assign slot_match  = job_valid_q[slot_q] && (job_name_q[slot_q] == cmd_q.job_id);
	assign slot_last   = (slot_q == SLOT_W'(MAX_JOBS - 1));
	assign free_frames = bpfa_pkg::COUNT_W'(FRAME_COUNT) - used_q;
	assign rel_frame   = ram_rdata[FIDX_W-1:0];

	// The decision taken once the job table walk is over.
	always_comb begin
		dec_state  = bpfa_pkg::ST_REPLY;
		dec_status = bpfa_pkg::STATUS_BADREQ;
		case (cmd_q.mode)
			bpfa_pkg::MODE_ALLOC: begin
				if (cmd_q.page_count == '0 || hit_q) begin
					dec_status = bpfa_pkg::STATUS_BADREQ;
				end else if (cmd_q.page_count > free_frames) begin
					dec_status = bpfa_pkg::STATUS_NOFRAMES;
				end else if (!free_q) begin
					dec_status = bpfa_pkg::STATUS_FULL;
				end else begin
					dec_status = bpfa_pkg::STATUS_OK;
					dec_state  = bpfa_pkg::ST_ALLOC;
				end
			end
			bpfa_pkg::MODE_RELEASE: begin
				if (!hit_q) begin
					dec_status = bpfa_pkg::STATUS_NOJOB;
				end else begin
					dec_status = bpfa_pkg::STATUS_OK;
					dec_state  = bpfa_pkg::ST_REL;
				end
			end
			bpfa_pkg::MODE_LOOKUP: begin
				if (!hit_q) begin
					dec_status = bpfa_pkg::STATUS_NOJOB;
				end else if (bpfa_pkg::COUNT_W'(cmd_q.page_index) >= pages_q) begin
					dec_status = bpfa_pkg::STATUS_RANGE;
				end else begin
					dec_status = bpfa_pkg::STATUS_OK;
					dec_state  = bpfa_pkg::ST_LOOK;
				end
			end
			default: begin
				dec_status = bpfa_pkg::STATUS_BADREQ;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpfa_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bpfa_pkg::ST_FIND;
				end
			end
			bpfa_pkg::ST_FIND: begin
				if (slot_last) begin
					state_d = bpfa_pkg::ST_DECIDE;
				end
			end
			bpfa_pkg::ST_DECIDE: begin
				state_d = dec_state;
			end
			bpfa_pkg::ST_ALLOC: begin
				if (alloc_last) begin
					state_d = bpfa_pkg::ST_IDLE;
				end
			end
			bpfa_pkg::ST_REL: begin
				if (rel_done) begin
					state_d = bpfa_pkg::ST_REPLY;
				end
			end
			bpfa_pkg::ST_LOOK: begin
				state_d = bpfa_pkg::ST_REPLY;
			end
			bpfa_pkg::ST_REPLY: begin
				if (out_free) begin
					state_d = bpfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bpfa_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready   = 1'b0;
		alloc_step = 1'b0;
		alloc_take = 1'b0;
		alloc_last = 1'b0;
		rel_issue  = 1'b0;
		rel_done   = 1'b0;
		out_load   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = {free_slot_q, page_cnt_q[bpfa_pkg::PAGE_W-1:0]};
		ram_wdata  = bpfa_pkg::FRAME_W'(frame_cnt_q);
		ram_raddr  = {hit_slot_q, page_cnt_q[bpfa_pkg::PAGE_W-1:0]};
		out_next.status      = reply_status_q;
		out_next.frame       = reply_frame_q;
		out_next.page_number = reply_page_q;
		out_next.frames_used = used_q;
		out_next.last        = 1'b1;
		case (state_q)
			bpfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			bpfa_pkg::ST_DECIDE: begin
				ram_raddr = {hit_slot_q, cmd_q.page_index};
			end
			bpfa_pkg::ST_ALLOC: begin
				alloc_step = out_free;
				alloc_take = out_free && !frame_map_q[frame_cnt_q];
				alloc_last = alloc_take && (page_cnt_q == cmd_q.page_count - 7'd1);
				ram_we     = alloc_take;
				out_load   = alloc_take;
				out_next.status      = bpfa_pkg::STATUS_OK;
				out_next.frame       = bpfa_pkg::FRAME_W'(frame_cnt_q);
				out_next.page_number = page_cnt_q[bpfa_pkg::PAGE_W-1:0];
				out_next.frames_used = alloc_total_q;
				out_next.last        = alloc_last;
			end
			bpfa_pkg::ST_REL: begin
				rel_issue = (page_cnt_q < pages_q);
				rel_done  = !rel_issue && !rel_v_s1;
			end
			bpfa_pkg::ST_REPLY: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::ST_IDLE;
			job_valid_q <= '0;
			frame_map_q <= PRESET;
			used_q      <= bpfa_pkg::COUNT_W'(PRESET_USED);
			rel_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rel_v_s1 <= rel_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (alloc_take) begin
				frame_map_q[frame_cnt_q] <= 1'b1;
				used_q <= used_q + 7'd1;
			end else if (rel_v_s1 && frame_map_q[rel_frame]) begin
				frame_map_q[rel_frame] <= 1'b0;
				used_q <= used_q - 7'd1;
			end
			if (alloc_last) begin
				job_valid_q[free_slot_q] <= 1'b1;
			end else if (rel_done) begin
				job_valid_q[hit_slot_q] <= 1'b0;
			end
		end
	end

	// Payload and counters, no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= in_item;
			slot_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end
		if (state_q == bpfa_pkg::ST_FIND) begin
			if (!slot_last) begin
				slot_q <= slot_q + 1'b1;
			end
			if (slot_match && !hit_q) begin
				hit_q      <= 1'b1;
				hit_slot_q <= slot_q;
				pages_q    <= job_pages_q[slot_q];
			end
			if (!job_valid_q[slot_q] && !free_q) begin
				free_q      <= 1'b1;
				free_slot_q <= slot_q;
			end
		end
		if (state_q == bpfa_pkg::ST_DECIDE) begin
			reply_status_q <= dec_status;
			reply_frame_q  <= '0;
			reply_page_q   <= (cmd_q.mode == bpfa_pkg::MODE_LOOKUP) ? cmd_q.page_index : '0;
			frame_cnt_q    <= '0;
			page_cnt_q     <= '0;
			alloc_total_q  <= used_q + cmd_q.page_count;
		end
		if (state_q == bpfa_pkg::ST_LOOK) begin
			reply_frame_q <= ram_rdata;
		end
		if (alloc_step) begin
			frame_cnt_q <= frame_cnt_q + 1'b1;
		end
		if (alloc_take || rel_issue) begin
			page_cnt_q <= page_cnt_q + 7'd1;
		end
		if (alloc_last) begin
			job_name_q[free_slot_q]  <= cmd_q.job_id;
			job_pages_q[free_slot_q] <= cmd_q.page_count;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	bpfa_page_ram #(
		.ADDR_W(ADDR_W)
	) u_page_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The used count always tracks the number of busy frames in the bitmap.
	a_used_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == bpfa_pkg::COUNT_W'($countones(frame_map_q)))
		else $error("used count differs from bitmap population");

	// A new request starts with the job table walk.
	a_accept_starts_find: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == bpfa_pkg::ST_FIND)
		else $error("accepted request did not start the search");

	// A release only runs on a job that was found.
	a_release_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bpfa_pkg::ST_REL |-> hit_q)
		else $error("release running without a matching job");

	// An allocation never runs past the number of frames.
	a_alloc_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bpfa_pkg::ST_ALLOC |-> alloc_total_q <= bpfa_pkg::COUNT_W'(FRAME_COUNT))
		else $error("allocation exceeds frame count");

endmodule

### rtl/core/bpfa_page_ram.sv
module bpfa_page_ram #(
	parameter int ADDR_W = 10
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ADDR_W-1:0]            waddr,
	input  logic [bpfa_pkg::FRAME_W-1:0] wdata,
	input  logic [ADDR_W-1:0]            raddr,
	output logic [bpfa_pkg::FRAME_W-1:0] rdata
);

	logic [bpfa_pkg::FRAME_W-1:0] mem [0:(1<<ADDR_W)-1];
	logic [bpfa_pkg::FRAME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
